// ----- hw/rtl/stt_pkg.sv -----
// Package: token codes, scanner modes and payload types for the text tokenizer.
`default_nettype none
package stt_pkg;

    localparam int OffsetWidthDef = 32;
    localparam int LengthWidthDef = 16;
    localparam int LineWidth      = 16;
    localparam int KindWidth      = 6;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_INT     = 3'd2,
        M_FRAC    = 3'd3,
        M_DOT     = 3'd4,
        M_OP      = 3'd5,
        M_COMMENT = 3'd6
    } t_mode;

    localparam logic [5:0] K_IDENT   = 6'd6;
    localparam logic [5:0] K_NUMBER  = 6'd7;
    localparam logic [5:0] K_DOT     = 6'd8;
    localparam logic [5:0] K_INVALID = 6'd46;
    localparam logic [5:0] K_EOF     = 6'd47;
    localparam logic [5:0] K_NONE    = 6'd63;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] text_byte;
    } t_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_result;
    } t_out;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Two-character operator, K_NONE when the pair does not combine.
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        k = K_NONE;
        case (a)
            "+": k = (b == "+") ? 6'd10 : (b == "=") ? 6'd11 : K_NONE;
            "-": k = (b == "-") ? 6'd13 : (b == ">") ? 6'd14 : (b == "=") ? 6'd15 : K_NONE;
            "*": k = (b == "*") ? 6'd17 : (b == "=") ? 6'd18 : K_NONE;
            "/": k = (b == "^") ? 6'd20 : (b == "_") ? 6'd21 : (b == "=") ? 6'd22 : K_NONE;
            "&": k = (b == "&") ? 6'd25 : K_NONE;
            "|": k = (b == "|") ? 6'd27 : K_NONE;
            "<": k = (b == "<") ? 6'd30 : (b == "=") ? 6'd31 : K_NONE;
            ">": k = (b == ">") ? 6'd33 : (b == "=") ? 6'd34 : K_NONE;
            "=": k = (b == "=") ? 6'd36 : K_NONE;
            ":": k = (b == ":") ? 6'd44 : K_NONE;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] a);
        logic [5:0] k;
        case (a)
            "+": k = 6'd9;  "-": k = 6'd12; "*": k = 6'd16; "/": k = 6'd19;
            "&": k = 6'd24; "|": k = 6'd26; "<": k = 6'd29; ">": k = 6'd32;
            "=": k = 6'd35; ":": k = 6'd43;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] plain_single(input logic [7:0] a);
        logic [5:0] k;
        case (a)
            "%": k = 6'd23; "^": k = 6'd28; "!": k = 6'd37; "(": k = 6'd38;
            ")": k = 6'd39; "{": k = 6'd40; "}": k = 6'd41; ",": k = 6'd42;
            ";": k = 6'd45;
            default: k = K_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] keyword_kind(input logic [47:0] w, input logic [2:0] len,
                                                input logic long_len);
        logic [5:0] k;
        k = K_IDENT;
        if (!long_len) begin
            if (len == 3'd2 && w == 48'h666E) k = 6'd0;
            if (len == 3'd6 && w == 48'h72657475726E) k = 6'd1;
            if (len == 3'd2 && w == 48'h6966) k = 6'd2;
            if (len == 3'd4 && w == 48'h656C7365) k = 6'd3;
            if (len == 3'd3 && w == 48'h6C6574) k = 6'd4;
            if (len == 3'd4 && w == 48'h6D61696E) k = 6'd5;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stt_scan.sv -----
// Scanner: per-byte next-state and token decision, registered scanner state.
`default_nettype none
module stt_scan #(
    parameter int OFFSET_WIDTH = stt_pkg::OffsetWidthDef,
    parameter int LENGTH_WIDTH = stt_pkg::LengthWidthDef
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire stt_pkg::t_in  i_item,
    output stt_pkg::t_out      o_tok_a,
    output logic               o_vld_a,
    output stt_pkg::t_out      o_tok_b,
    output logic               o_vld_b
);
    localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;
    localparam logic [LENGTH_WIDTH-1:0] LenOne = LENGTH_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0] LenSix = LENGTH_WIDTH'(6);

    stt_pkg::t_mode            r_mode, n_mode;
    logic [7:0]                r_op, n_op;
    logic [47:0]               r_win, n_win;
    logic [LENGTH_WIDTH-1:0]   r_len, n_len;
    logic [OFFSET_WIDTH-1:0]   r_start, n_start;
    logic [OFFSET_WIDTH-1:0]   r_off, n_off;
    logic [15:0]               r_line, n_line;

    logic [7:0]              c;
    logic                    done;
    logic [5:0]              pk, fk;
    logic                    fv;
    logic [LENGTH_WIDTH-1:0] grown;
    logic [2:0]              len3;
    logic                    len_long;
    logic [15:0]             line_after;

    function automatic stt_pkg::t_out mk(input logic [5:0] k, input logic [OFFSET_WIDTH-1:0] s,
                                         input logic [LENGTH_WIDTH-1:0] l,
                                         input logic [15:0] ln);
        stt_pkg::t_out t;
        t.token_kind   = k;
        t.start_offset = 32'(s);
        t.token_length = 16'(l);
        t.line_number  = ln;
        t.last_result  = 1'b0;
        return t;
    endfunction

    always_comb begin
        c        = i_item.text_byte;
        grown    = (r_len != LenMax) ? r_len + LenOne : r_len;
        len_long = r_len > LenSix;
        len3     = 3'(r_len);
        pk       = stt_pkg::pair_kind(r_op, c);
        // kind of pending token when flushed
        fv = 1'b1;
        case (r_mode)
            stt_pkg::M_IDENT: fk = stt_pkg::keyword_kind(r_win, len3, len_long);
            stt_pkg::M_INT, stt_pkg::M_FRAC: fk = stt_pkg::K_NUMBER;
            stt_pkg::M_DOT:   fk = stt_pkg::K_DOT;
            stt_pkg::M_OP:    fk = stt_pkg::op_single(r_op);
            default: begin fk = stt_pkg::K_NONE; fv = 1'b0; end
        endcase
        line_after = (c == 8'h0A && r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;

        n_mode = r_mode; n_op = r_op; n_win = r_win; n_len = r_len;
        n_start = r_start; n_off = r_off + OFFSET_WIDTH'(1); n_line = r_line;
        o_tok_a = mk(fk, r_start, r_len, r_line); o_vld_a = 1'b0;
        o_tok_b = mk(stt_pkg::K_EOF, r_off, '0, r_line); o_vld_b = 1'b0;
        done = 1'b0;

        if (i_item.command == stt_pkg::CMD_END) begin
            o_vld_a = fv;
            o_vld_b = 1'b1;
            n_mode = stt_pkg::M_IDLE; n_op = '0; n_win = '0; n_len = '0;
            n_start = '0; n_off = '0; n_line = '0;
        end else begin
            case (r_mode)
                stt_pkg::M_IDENT: if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
                    if (r_len < LenSix) n_win = {r_win[39:0], c};
                    n_len = grown; done = 1'b1;
                end
                stt_pkg::M_INT: if (stt_pkg::is_digit(c)) begin
                    n_len = grown; done = 1'b1;
                end else if (c == ".") begin
                    n_len = grown; n_mode = stt_pkg::M_FRAC; done = 1'b1;
                end
                stt_pkg::M_FRAC: if (stt_pkg::is_digit(c)) begin
                    n_len = grown; done = 1'b1;
                end
                stt_pkg::M_DOT: if (stt_pkg::is_digit(c)) begin
                    n_len = grown; n_mode = stt_pkg::M_FRAC; done = 1'b1;
                end
                stt_pkg::M_OP: if (pk != stt_pkg::K_NONE) begin
                    o_tok_a = mk(pk, r_start, LENGTH_WIDTH'(2), r_line);
                    o_vld_a = 1'b1; n_mode = stt_pkg::M_IDLE; done = 1'b1;
                end
                stt_pkg::M_COMMENT: if (c != 8'h0A) done = 1'b1;
                default: done = 1'b0;
            endcase
            if (!done) begin
                // flush pending token (comment flushes nothing), then start afresh
                o_vld_a = fv;
                n_mode = stt_pkg::M_IDLE; n_start = r_off; n_len = LenOne;
                if (stt_pkg::is_space(c)) begin
                    n_line = line_after;
                end else if (c == "#") begin
                    n_mode = stt_pkg::M_COMMENT;
                end else if (stt_pkg::is_alpha(c)) begin
                    n_mode = stt_pkg::M_IDENT; n_win = {40'd0, c};
                end else if (stt_pkg::is_digit(c)) begin
                    n_mode = stt_pkg::M_INT;
                end else if (c == ".") begin
                    n_mode = stt_pkg::M_DOT;
                end else if (stt_pkg::op_single(c) != stt_pkg::K_NONE) begin
                    n_mode = stt_pkg::M_OP; n_op = c;
                end else begin
                    o_tok_b = mk(stt_pkg::plain_single(c), r_off, LenOne, r_line);
                    o_vld_b = 1'b1;
                end
            end
        end
        if (o_vld_b) o_tok_b.last_result = 1'b1;
        else o_tok_a.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stt_pkg::M_IDLE; r_op <= '0; r_win <= '0; r_len <= '0;
            r_start <= '0; r_off <= '0; r_line <= '0;
        end else if (i_step) begin
            r_mode <= n_mode; r_op <= n_op; r_win <= n_win; r_len <= n_len;
            r_start <= n_start; r_off <= n_off; r_line <= n_line;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/stt_outq.sv -----
// Output queue: four-entry FIFO of tokens, up to two pushed per cycle.
`default_nettype none
module stt_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_a,
    input  wire stt_pkg::t_out i_tok_a,
    input  wire logic          i_push_b,
    input  wire stt_pkg::t_out i_tok_b,
    input  wire logic          i_pop,
    output stt_pkg::t_out      o_head,
    output logic               o_valid,
    output logic               o_room2
);
    stt_pkg::t_out r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] wp_b;

    assign o_head  = r_mem[r_rp];
    assign o_valid = r_cnt != 3'd0;
    assign o_room2 = r_cnt <= 3'd2;
    assign wp_b    = i_push_a ? r_wp + 2'd1 : r_wp;
    assign n_cnt   = r_cnt + {2'b0, i_push_a} + {2'b0, i_push_b} - {2'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (i_push_a) r_mem[r_wp] <= i_tok_a;
        if (i_push_b) r_mem[wp_b] <= i_tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + {1'b0, i_push_a} + {1'b0, i_push_b};
            r_rp  <= r_rp + {1'b0, i_pop};
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/source_text_tokenizer.sv -----
// Top level of the streaming text tokenizer.
//
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_ready   | i_data  (command, text_byte)
//  output  | out       | o_valid / i_ready   | o_data  (kind, offset, length, line, last)
//
// One byte per cycle: the scanner state updates in the cycle of the input transfer,
// and zero to two tokens go into a four-entry output queue.
// Tokens appear on the output the cycle after the byte's transfer at the earliest.
// Input is held off only when the queue has fewer than two free entries.
// Reset (synchronous, active low) clears scanner state and empties the queue.
`default_nettype none
module source_text_tokenizer #(
    parameter int OFFSET_WIDTH = stt_pkg::OffsetWidthDef,
    parameter int LENGTH_WIDTH = stt_pkg::LengthWidthDef
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire stt_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output stt_pkg::t_out      o_data
);
    stt_pkg::t_out tok_a, tok_b;
    logic vld_a, vld_b, step, room2;

    // accept when two free slots remain so one byte's tokens always fit
    assign o_ready = room2;
    assign step    = i_valid && room2;

    stt_scan #(.OFFSET_WIDTH(OFFSET_WIDTH), .LENGTH_WIDTH(LENGTH_WIDTH)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_item(i_data),
        .o_tok_a(tok_a), .o_vld_a(vld_a), .o_tok_b(tok_b), .o_vld_b(vld_b)
    );

    stt_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_a(step && vld_a), .i_tok_a(tok_a),
        .i_push_b(step && vld_b), .i_tok_b(tok_b),
        .i_pop(o_valid && i_ready),
        .o_head(o_data), .o_valid(o_valid), .o_room2(room2)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/stt_checker.sv -----
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none
module stt_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          o_ready,
    input wire stt_pkg::t_in  i_data,
    input wire logic          o_valid,
    input wire logic          i_ready,
    input wire stt_pkg::t_out o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output not held");
    a_eof_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.token_kind == stt_pkg::K_EOF |-> o_data.token_length == 16'd0
        && o_data.last_result) else $error("bad eof token");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.token_kind <= stt_pkg::K_EOF) else $error("kind out of range");
    a_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.command == stt_pkg::CMD_END |=> o_valid)
        else $error("no token after end");
endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
`default_nettype wire
